[rtl/ptns_pkg.sv]
// ----------------------------------------------------------------------------
// ptns_pkg
// Shared constants and types of the point table with nearest search.
// ----------------------------------------------------------------------------
package ptns_pkg;

  localparam int POINTS = 64;
  localparam int IDX_W  = $clog2(POINTS);
  localparam int CNT_W  = $clog2(POINTS + 1);

  localparam logic [2:0] CMD_ADD        = 3'd0;
  localparam logic [2:0] CMD_ADD_ANCHOR = 3'd1;
  localparam logic [2:0] CMD_REMOVE     = 3'd2;
  localparam logic [2:0] CMD_READ       = 3'd3;
  localparam logic [2:0] CMD_NEAREST    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOTFOUND  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } slot_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } ptns_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
    logic out_blocked;
  } ptns_sts_t;

endpackage

[rtl/ptns_ctrl.sv]
// ----------------------------------------------------------------------------
// ptns_ctrl
// Sequencer: takes one transaction, runs the slot scan, drains the
// datapath pipeline and commits the result.
// ----------------------------------------------------------------------------
module ptns_ctrl import ptns_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ptns_sts_t sts_i,
  output ptns_cmd_t ctl_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl_o.issue = 1'b1;
        if (sts_i.scan_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output register is free
        if (!sts_i.out_blocked) begin
          ctl_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/ptns_dp.sv]
// ----------------------------------------------------------------------------
// ptns_dp
// Datapath: slot memory, valid bits, three-stage scan pipeline (read,
// square, compare), ID counter, point count and output register.
// ----------------------------------------------------------------------------
module ptns_dp import ptns_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptns_cmd_t          ctl_i,
  output ptns_sts_t          sts_o,
  input  logic [2:0]         cmd_i,
  input  logic [15:0]        target_id_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [15:0]        result_id_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [15:0] out_z_o,
  output logic [6:0]         point_count_o
);

  // captured transaction
  logic [2:0]  cmd_q;
  logic [15:0] tid_q, px_q, py_q, pz_q;

  // slot storage
  slot_t             mem_q [POINTS];
  slot_t             rd_q;
  logic [POINTS-1:0] slot_vld_q;

  // scan pipeline
  logic [IDX_W-1:0] idx_q;
  logic             s1_v_q, s1_vbit_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             s2_v_q, s2_vbit_q;
  logic [IDX_W-1:0] s2_idx_q;
  slot_t            s2_slot_q;
  logic [31:0]      s2_dxsq_q, s2_dzsq_q;

  // scan results
  logic             free_hit_q, match_hit_q, best_hit_q;
  logic [IDX_W-1:0] free_idx_q, match_idx_q;
  slot_t            match_slot_q, best_slot_q;
  logic [32:0]      best_dist_q;

  // table state
  logic [15:0]      next_id_q;
  logic             exhausted_q;
  logic [CNT_W-1:0] count_q, count_d;

  // output register
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [15:0] out_id_q, out_x_q, out_y_q, out_z_q;
  logic [6:0]  out_count_q;

  logic [16:0] dx, dz, dx_neg, dz_neg;
  logic [15:0] dx_mag, dz_mag;
  logic [32:0] dist_sum;
  logic        better;

  logic [1:0]  res_status;
  logic [15:0] res_id, res_x, res_y, res_z;
  logic        wr_en, cnt_inc, cnt_dec;

  assign sts_o.scan_last   = (idx_q == IDX_W'(POINTS - 1));
  assign sts_o.pipe_busy   = s1_v_q | s2_v_q;
  assign sts_o.out_blocked = out_valid_q & out_stall_i;

  // stage 1: distance components
  always_comb begin
    dx     = {px_q[15], px_q} - {rd_q.x[15], rd_q.x};
    dz     = {pz_q[15], pz_q} - {rd_q.z[15], rd_q.z};
    dx_neg = 17'd0 - dx;
    dz_neg = 17'd0 - dz;
    dx_mag = dx[16] ? dx_neg[15:0] : dx[15:0];
    dz_mag = dz[16] ? dz_neg[15:0] : dz[15:0];
  end

  // stage 2: sum and compare, ties go to the lower id
  always_comb begin
    dist_sum = {1'b0, s2_dxsq_q} + {1'b0, s2_dzsq_q};
    better   = !best_hit_q || (dist_sum < best_dist_q) ||
               ((dist_sum == best_dist_q) && (s2_slot_q.id < best_slot_q.id));
  end

  // result of the transaction once the scan is done
  always_comb begin
    res_status = ST_NOTFOUND;
    res_id     = '0;
    res_x      = '0;
    res_y      = '0;
    res_z      = '0;
    wr_en      = 1'b0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    case (cmd_q)
      CMD_ADD, CMD_ADD_ANCHOR: begin
        if (cmd_q == CMD_ADD || match_hit_q) begin
          if (!free_hit_q) begin
            res_status = ST_FULL;
          end else if (exhausted_q) begin
            res_status = ST_EXHAUSTED;
          end else begin
            res_status = ST_OK;
            res_id     = next_id_q;
            wr_en      = 1'b1;
            cnt_inc    = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        if (match_hit_q) begin
          res_status = ST_OK;
          res_id     = tid_q;
          cnt_dec    = 1'b1;
        end
      end
      CMD_READ: begin
        if (match_hit_q) begin
          res_status = ST_OK;
          res_id     = tid_q;
          res_x      = match_slot_q.x;
          res_y      = match_slot_q.y;
          res_z      = match_slot_q.z;
        end
      end
      CMD_NEAREST: begin
        if (best_hit_q) begin
          res_status = ST_OK;
          res_id     = best_slot_q.id;
          res_x      = best_slot_q.x;
          res_y      = best_slot_q.y;
          res_z      = best_slot_q.z;
        end
      end
      default: begin
      end
    endcase
    count_d = count_q + CNT_W'(cnt_inc) - CNT_W'(cnt_dec);
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.commit && wr_en) begin
      mem_q[free_idx_q] <= '{id: next_id_q, x: px_q, y: py_q, z: pz_q};
    end
    rd_q <= mem_q[idx_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      tid_q <= target_id_i;
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      pz_q  <= pos_z_i;
    end
    s1_idx_q  <= idx_q;
    s1_vbit_q <= slot_vld_q[idx_q];
    s2_idx_q  <= s1_idx_q;
    s2_vbit_q <= s1_vbit_q;
    s2_slot_q <= rd_q;
    s2_dxsq_q <= {16'd0, dx_mag} * {16'd0, dx_mag};
    s2_dzsq_q <= {16'd0, dz_mag} * {16'd0, dz_mag};
    if (s2_v_q) begin
      if (!s2_vbit_q && !free_hit_q) free_idx_q <= s2_idx_q;
      if (s2_vbit_q && s2_slot_q.id == tid_q && !match_hit_q) begin
        match_idx_q  <= s2_idx_q;
        match_slot_q <= s2_slot_q;
      end
      if (s2_vbit_q && better) begin
        best_dist_q <= dist_sum;
        best_slot_q <= s2_slot_q;
      end
    end
    if (ctl_i.commit) begin
      out_status_q <= res_status;
      out_id_q     <= res_id;
      out_x_q      <= res_x;
      out_y_q      <= res_y;
      out_z_q      <= res_z;
      out_count_q  <= 7'(count_d);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      free_hit_q  <= 1'b0;
      match_hit_q <= 1'b0;
      best_hit_q  <= 1'b0;
      slot_vld_q  <= '0;
      next_id_q   <= '0;
      exhausted_q <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_v_q <= ctl_i.issue;
      s2_v_q <= s1_v_q;
      if (ctl_i.load) begin
        idx_q       <= '0;
        free_hit_q  <= 1'b0;
        match_hit_q <= 1'b0;
        best_hit_q  <= 1'b0;
      end else if (ctl_i.issue) begin
        idx_q <= sts_o.scan_last ? '0 : idx_q + IDX_W'(1);
      end
      if (s2_v_q) begin
        if (!s2_vbit_q) free_hit_q <= 1'b1;
        if (s2_vbit_q && s2_slot_q.id == tid_q) match_hit_q <= 1'b1;
        if (s2_vbit_q) best_hit_q <= 1'b1;
      end
      if (ctl_i.commit) begin
        count_q <= count_d;
        if (wr_en) begin
          slot_vld_q[free_idx_q] <= 1'b1;
          if (next_id_q == 16'hFFFF) begin
            exhausted_q <= 1'b1;
          end else begin
            next_id_q <= next_id_q + 16'd1;
          end
        end
        if (cnt_dec) slot_vld_q[match_idx_q] <= 1'b0;
      end
      if (ctl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign result_id_o   = out_id_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_z_o       = out_z_q;
  assign point_count_o = out_count_q;

endmodule

[rtl/point_table_nearest_search.sv]
// ----------------------------------------------------------------------------
// point_table_nearest_search
// Table of up to POINTS points with add, anchored add, remove, read by id
// and nearest search in the x-z plane.
//
// Input channel: in_valid_i / in_stall_o with cmd_i, target_id_i and
// pos_x_i, pos_y_i, pos_z_i. Output channel: out_valid_o / out_stall_i
// with status_o, result_id_o, out_x_o, out_y_o, out_z_o, point_count_o.
// Every transaction gives exactly one result.
// Each command scans all POINTS slots, one slot memory read per cycle,
// through a read / square / compare pipeline. The next transaction is
// accepted only once the result of the last one has been committed.
// Reset empties the table, clears the id counter and the count; the slot
// memory itself is not cleared. A stalled result stays in the output
// register while the next transaction is accepted and scanned; its commit
// waits until the output register is free.
// ----------------------------------------------------------------------------
module point_table_nearest_search import ptns_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic [15:0]        target_id_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [15:0]        result_id_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [15:0] out_z_o,
  output logic [6:0]         point_count_o
);

  ptns_cmd_t ctl;
  ptns_sts_t sts;

  ptns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ptns_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cmd_i         (cmd_i),
    .target_id_i   (target_id_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .result_id_o   (result_id_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_z_o       (out_z_o),
    .point_count_o (point_count_o)
  );

`ifndef SYNTH
  // one transaction at a time: a scan follows every acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("transaction accepted while a scan should be running");

  // failing results carry no id
  a_fail_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (result_id_o == 16'd0))
    else $error("nonzero id on a failing result");

  // table full is only reported with every slot taken
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (point_count_o == 7'(POINTS)))
    else $error("table full reported with free slots");

  // a commit never lands on a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_id_o)))
    else $error("stalled result overwritten");
`endif

endmodule
